// ===== rtl/core/ufa_pkg.sv =====
// Shared types, codes and code-point mapping for the UTF-8 to ASCII folder.
package ufa_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [6:0] ascii_char;
    logic       run_last;
  } out_item_t;

  // Action the front of the held bytes calls for.
  localparam logic [1:0] ACT_STOP = 2'd0;
  localparam logic [1:0] ACT_DROP = 2'd1;
  localparam logic [1:0] ACT_EMIT = 2'd2;

  localparam logic [6:0] CH_QUOTE  = 7'h27;
  localparam logic [6:0] CH_DQUOTE = 7'h22;
  localparam logic [6:0] CH_DASH   = 7'h2D;
  localparam logic [6:0] CH_DOT    = 7'h2E;
  localparam logic [6:0] CH_QMARK  = 7'h3F;

  typedef struct packed {
    logic       load;
    logic       advance;
    logic       finish;
  } ufa_cmd_t;

  typedef struct packed {
    logic [1:0] act;
    logic       last_emit;   // this emission empties the held bytes
    logic       pend_valid;
    logic       out_free;
  } ufa_status_t;

  // Latin letters of the two-byte range; zero when the code point has no fold.
  function automatic logic [6:0] fold_two_byte(input logic [10:0] cp);
    logic [6:0] f;
    f = 7'd0;
    if (cp inside {[11'h0C0:11'h0C5]}) f = 7'h41;
    else if (cp == 11'h0C7) f = 7'h43;
    else if (cp inside {[11'h0C8:11'h0CB]}) f = 7'h45;
    else if (cp inside {[11'h0CC:11'h0CF]}) f = 7'h49;
    else if (cp == 11'h0D1) f = 7'h4E;
    else if (cp inside {[11'h0D2:11'h0D6], 11'h0D8}) f = 7'h4F;
    else if (cp inside {[11'h0D9:11'h0DC]}) f = 7'h55;
    else if (cp == 11'h0DD) f = 7'h59;
    else if (cp inside {[11'h0E0:11'h0E5]}) f = 7'h61;
    else if (cp == 11'h0E7) f = 7'h63;
    else if (cp inside {[11'h0E8:11'h0EB]}) f = 7'h65;
    else if (cp inside {[11'h0EC:11'h0EF]}) f = 7'h69;
    else if (cp == 11'h0F1) f = 7'h6E;
    else if (cp inside {[11'h0F2:11'h0F6], 11'h0F8}) f = 7'h6F;
    else if (cp inside {[11'h0F9:11'h0FC]}) f = 7'h75;
    else if (cp inside {11'h0FD, 11'h0FF}) f = 7'h79;
    else if (cp inside {11'h106, 11'h108, 11'h10A, 11'h10C}) f = 7'h43;
    else if (cp inside {11'h107, 11'h109, 11'h10B, 11'h10D}) f = 7'h63;
    else if (cp == 11'h152) f = 7'h4F;
    else if (cp == 11'h153) f = 7'h6F;
    else if (cp == 11'h160) f = 7'h53;
    else if (cp == 11'h161) f = 7'h73;
    else if (cp == 11'h17D) f = 7'h5A;
    else if (cp == 11'h17E) f = 7'h7A;
    return f;
  endfunction

  // Returns {ellipsis, char}; for the ellipsis the char is the dot.
  function automatic logic [7:0] map_cp(input logic [2:0] len, input logic [20:0] cp);
    logic [6:0] f;
    logic [7:0] r;
    f = (len == 3'd2) ? fold_two_byte(cp[10:0]) : 7'd0;
    if (f != 7'd0) r = {1'b0, f};
    else if (cp inside {21'h2018, 21'h2019}) r = {1'b0, CH_QUOTE};
    else if (cp inside {21'h201C, 21'h201D}) r = {1'b0, CH_DQUOTE};
    else if (cp inside {21'h2013, 21'h2014}) r = {1'b0, CH_DASH};
    else if (cp == 21'h2026) r = {1'b1, CH_DOT};
    else r = {1'b0, CH_QMARK};
    return r;
  endfunction

endpackage

// ===== rtl/core/ufa_ctrl.sv =====
// Sequencer: accepts a byte, then steps the datapath until the held bytes stall.
module ufa_ctrl
  import ufa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  ufa_status_t status,
  output ufa_cmd_t    cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_PROC = 1'b1;

  logic state;
  logic state_next;
  logic need_slot;

  assign in_stall  = (state != ST_IDLE);
  assign need_slot = status.pend_valid || status.last_emit;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_PROC;
        end
      end
      ST_PROC: begin
        case (status.act)
          ACT_STOP: begin
            if (!status.pend_valid || status.out_free) begin
              cmd.finish = 1'b1;
              state_next = ST_IDLE;
            end
          end
          ACT_DROP: begin
            cmd.advance = 1'b1;
          end
          ACT_EMIT: begin
            if (!need_slot || status.out_free) begin
              cmd.advance = 1'b1;
              // last char of the step, nothing pending: it goes straight out
              if (status.last_emit && !status.pend_valid) state_next = ST_IDLE;
            end
          end
          default: begin
            state_next = state;
          end
        endcase
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/core/ufa_dp.sv =====
// Datapath: held bytes, front decode, pending char and output register.
module ufa_dp
  import ufa_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  in_item_t    in_data,
  input  ufa_cmd_t    cmd,
  output ufa_status_t status,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data
);

  logic [7:0] held [4];
  logic [2:0] cnt;
  logic       eos;
  logic [1:0] rep;
  logic [6:0] pend;
  logic       pend_valid;

  logic [7:0] c;
  logic       is_ascii, lead2, lead3, lead4, is_lead;
  logic [2:0] len;
  logic       b1ok, b2ok, b3ok, cont_ok;
  logic [20:0] cp;
  logic [7:0] mapped;
  logic       ell;
  logic [6:0] ch;
  logic [2:0] k;
  logic       emit_done;
  logic [1:0] act;
  logic       last_emit;
  logic       out_free;
  logic       push;
  out_item_t  push_data;
  logic [7:0] held_shift [4];
  logic [2:0] src [4];

  assign c        = held[0];
  assign is_ascii = !c[7];
  assign lead2    = (c[7:5] == 3'b110);
  assign lead3    = (c[7:4] == 4'b1110);
  assign lead4    = (c[7:3] == 5'b11110);
  assign is_lead  = lead2 || lead3 || lead4;
  assign len      = lead2 ? 3'd2 : (lead3 ? 3'd3 : 3'd4);

  assign b1ok    = (held[1][7:6] == 2'b10);
  assign b2ok    = (held[2][7:6] == 2'b10);
  assign b3ok    = (held[3][7:6] == 2'b10);
  assign cont_ok = b1ok && (len < 3'd3 || b2ok) && (len < 3'd4 || b3ok);

  always_comb begin
    case (len)
      3'd2:    cp = {10'd0, c[4:0], held[1][5:0]};
      3'd3:    cp = {5'd0, c[3:0], held[1][5:0], held[2][5:0]};
      default: cp = {c[2:0], held[1][5:0], held[2][5:0], held[3][5:0]};
    endcase
  end

  assign mapped = map_cp(len, cp);

  always_comb begin
    act = ACT_STOP;
    ell = 1'b0;
    ch  = CH_QMARK;
    k   = 3'd1;
    if (cnt == 3'd0) begin
      act = ACT_STOP;
    end else if (is_ascii) begin
      act = ACT_EMIT;
      ch  = c[6:0];
    end else if (!is_lead) begin
      act = ACT_DROP;
    end else if (cnt < len) begin
      act = ACT_STOP;
    end else if (!cont_ok) begin
      act = ACT_DROP;
    end else begin
      act = ACT_EMIT;
      ell = mapped[7];
      ch  = mapped[6:0];
      k   = len;
    end
  end

  // ellipsis repeats its dot three times before the window is dropped
  assign emit_done = !ell || (rep == 2'd2);
  assign last_emit = (act == ACT_EMIT) && emit_done && (k == cnt);
  assign out_free  = !out_valid || !out_stall;

  assign status.act        = act;
  assign status.last_emit  = last_emit;
  assign status.pend_valid = pend_valid;
  assign status.out_free   = out_free;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      src[i]        = 3'(i) + k;
      held_shift[i] = (src[i] < 3'd4) ? held[src[i][1:0]] : held[i];
    end
  end

  always_comb begin
    push      = 1'b0;
    push_data = '{ascii_char: pend, run_last: 1'b0};
    if (cmd.advance && act == ACT_EMIT) begin
      if (pend_valid) begin
        push = 1'b1;
      end else if (last_emit) begin
        push      = 1'b1;
        push_data = '{ascii_char: ch, run_last: 1'b1};
      end
    end else if (cmd.finish && pend_valid) begin
      push      = 1'b1;
      push_data = '{ascii_char: pend, run_last: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      held[cnt[1:0]] <= in_data.in_byte;
    end else if (cmd.advance && emit_done) begin
      for (int i = 0; i < 4; i++) held[i] <= held_shift[i];
    end
    if (cmd.load) eos <= in_data.end_of_string;
    if (cmd.advance && act == ACT_EMIT && (pend_valid || !last_emit)) pend <= ch;
    if (push) out_data <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= 3'd0;
      rep        <= 2'd0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.load) begin
        cnt <= cnt + 3'd1;
      end else if (cmd.advance) begin
        if (emit_done) begin
          cnt <= cnt - k;
          rep <= 2'd0;
        end else begin
          rep <= rep + 2'd1;
        end
      end else if (cmd.finish && eos) begin
        cnt <= 3'd0;
      end

      if (cmd.advance && act == ACT_EMIT) begin
        pend_valid <= pend_valid || !last_emit;
      end else if (cmd.finish) begin
        pend_valid <= 1'b0;
      end

      if (push) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  a_load_room: assert property (@(posedge clk) disable iff (rst) cmd.load |-> cnt <= 3'd3)
    else $error("byte loaded with no room in the window");
  a_rep_range: assert property (@(posedge clk) disable iff (rst) rep != 2'd3)
    else $error("ellipsis repeat count out of range");
  a_push_free: assert property (@(posedge clk) disable iff (rst) push |-> out_free)
    else $error("output overwritten while stalled");
  a_finish_clr: assert property (@(posedge clk) disable iff (rst) cmd.finish |=> !pend_valid)
    else $error("pending char left after step end");

endmodule

// ===== rtl/core/utf8_to_ascii_fold_top.sv =====
// Top level of the UTF-8 to ASCII folder: sequencer plus datapath.
// A plain ASCII byte is loaded into the window, then emitted into the output register.
// Steps: a load, one datapath action per dropped byte or emitted char, then a closing
// step; a lone char that ends the walk leaves in its emit step, with no closing step.
// Output stall holds the walk. Reset (rst, sync, active high) empties the window and clears
// pending and output valid; held byte storage is not cleared.
module utf8_to_ascii_fold_top
  import ufa_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // command and status between sequencer and datapath
  ufa_cmd_t    cmd;
  ufa_status_t status;

  // sequencer: one transfer in, then one datapath action per cycle while the output is free
  ufa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: window of held bytes, decode/map, one-char pending stage, output reg
  ufa_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
